@@ sv/slfr_pkg.sv @@
// Shared types and constants for the sync/length frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package slfr_pkg;

  localparam int PAYLOAD_BYTES = 32;
  localparam int FRAME_BYTES   = PAYLOAD_BYTES + 4;
  localparam int FRAME_LEN_SAT = (FRAME_BYTES > 63) ? 63 : FRAME_BYTES;

  typedef logic [7:0] byte_t;
  typedef logic [5:0] pos_t;

  // index of the last payload byte; the next byte is the checksum
  localparam pos_t LAST_PAYLOAD = pos_t'(PAYLOAD_BYTES + 2);

  localparam byte_t SYNC_BYTE_RST   = 8'hAA;
  localparam byte_t LENGTH_CODE_RST = 8'h20;

  typedef enum logic [2:0] {
    STEP_SYNC1 = 3'd0,
    STEP_SYNC2 = 3'd1,
    STEP_LEN   = 3'd2,
    STEP_DATA  = 3'd3,
    STEP_SUM   = 3'd4
  } step_t;

  typedef enum logic [1:0] {
    ST_IGNORED = 2'd0,
    ST_STORED  = 2'd1,
    ST_DONE    = 2'd2,
    ST_ABORT   = 2'd3
  } status_t;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_BYTE   = 1'b0,
    CFG_LENGTH_CODE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    byte_t sync_byte;
    byte_t length_code;
  } cfg_t;

  typedef struct packed {
    status_t status;
    pos_t    position;
    byte_t   data_byte;
    pos_t    frame_length;
  } result_t;

endpackage

`default_nettype wire

@@ sv/slfr_if.sv @@
// Valid/ready channel interfaces for received bytes and parse results.
`timescale 1ns / 1ps
`default_nettype none

interface slfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] position;
  logic [7:0] data_byte;
  logic [5:0] frame_length;

  modport source (output valid, output status, output position, output data_byte,
                  output frame_length, input ready);
  modport sink   (input valid, input status, input position, input data_byte,
                  input frame_length, output ready);
endinterface

`default_nettype wire

@@ sv/slfr_parser.sv @@
// Frame step sequencer: holds step and byte position, classifies each byte.
`timescale 1ns / 1ps
`default_nettype none

module slfr_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire slfr_pkg::byte_t  rx_byte,
  input  wire slfr_pkg::cfg_t   cfg,
  output slfr_pkg::result_t     res
);

  slfr_pkg::step_t step_r, step_nxt;
  slfr_pkg::pos_t  pos_r, pos_nxt;

  logic           sync_hit;
  logic           len_hit;
  slfr_pkg::pos_t pos_inc;
  logic [6:0]     total;

  assign sync_hit = (rx_byte == cfg.sync_byte);
  assign len_hit  = (rx_byte == cfg.length_code);
  assign pos_inc  = pos_r + 6'd1;
  assign total    = {1'b0, pos_r} + 7'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= slfr_pkg::STEP_SYNC1;
      pos_r  <= '0;
    end else begin
      step_r <= step_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // next state
  always_comb begin
    step_nxt = step_r;
    pos_nxt  = pos_r;
    if (advance) begin
      case (step_r)
        slfr_pkg::STEP_SYNC2: begin
          step_nxt = sync_hit ? slfr_pkg::STEP_LEN : slfr_pkg::STEP_SYNC1;
          pos_nxt  = sync_hit ? pos_inc : '0;
        end
        slfr_pkg::STEP_LEN: begin
          step_nxt = len_hit ? slfr_pkg::STEP_DATA : slfr_pkg::STEP_SYNC1;
          pos_nxt  = len_hit ? pos_inc : '0;
        end
        slfr_pkg::STEP_DATA: begin
          if (pos_r >= slfr_pkg::LAST_PAYLOAD) begin
            step_nxt = slfr_pkg::STEP_SUM;
          end
          pos_nxt = pos_inc;
        end
        slfr_pkg::STEP_SUM: begin
          step_nxt = slfr_pkg::STEP_SYNC1;
          pos_nxt  = '0;
        end
        default: begin
          step_nxt = sync_hit ? slfr_pkg::STEP_SYNC2 : slfr_pkg::STEP_SYNC1;
          pos_nxt  = sync_hit ? 6'd1 : 6'd0;
        end
      endcase
    end
  end

  // result for the byte at the input
  always_comb begin
    res.status       = slfr_pkg::ST_IGNORED;
    res.position     = '0;
    res.data_byte    = '0;
    res.frame_length = '0;
    case (step_r)
      slfr_pkg::STEP_SYNC2: begin
        if (sync_hit) begin
          res.status    = slfr_pkg::ST_STORED;
          res.position  = pos_r;
          res.data_byte = rx_byte;
        end else begin
          res.status = slfr_pkg::ST_ABORT;
        end
      end
      slfr_pkg::STEP_LEN: begin
        if (len_hit) begin
          res.status    = slfr_pkg::ST_STORED;
          res.position  = pos_r;
          res.data_byte = rx_byte;
        end else begin
          res.status = slfr_pkg::ST_ABORT;
        end
      end
      slfr_pkg::STEP_DATA: begin
        res.status    = slfr_pkg::ST_STORED;
        res.position  = pos_r;
        res.data_byte = rx_byte;
      end
      slfr_pkg::STEP_SUM: begin
        res.status       = slfr_pkg::ST_DONE;
        res.position     = pos_r;
        res.data_byte    = rx_byte;
        res.frame_length = total[6] ? 6'd63 : total[5:0];
      end
      default: begin
        if (sync_hit) begin
          res.status    = slfr_pkg::ST_STORED;
          res.data_byte = rx_byte;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/sync_length_frame_receiver.sv @@
// Top level of the sync/length frame receiver.
// Each accepted request's result is captured in the output register and presented on out_req.
// Throughput: one byte per cycle while results are taken; exactly one result per accepted byte.
// in_req.ready is low only while a result sits in the output register unaccepted.
// Reset (rst_n low, synchronous): frame step back to first sync, position 0,
// output register empty, sync_byte = 0xAA, length_code = 0x20.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_frame_receiver (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  slfr_in_if.sink                                  in_req,
  slfr_out_if.source                               out_req,
  input  wire logic                                cfg_we,
  input  wire logic [slfr_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [7:0]                          cfg_wdata
);

  // configuration registers
  slfr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte   <= slfr_pkg::SYNC_BYTE_RST;
      cfg_r.length_code <= slfr_pkg::LENGTH_CODE_RST;
    end else if (cfg_we) begin
      case (slfr_pkg::cfg_idx_t'(cfg_addr))
        slfr_pkg::CFG_SYNC_BYTE:   cfg_r.sync_byte   <= cfg_wdata;
        slfr_pkg::CFG_LENGTH_CODE: cfg_r.length_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake: output register may refill in the same cycle it drains
  logic in_fire;
  logic out_valid_r;
  slfr_pkg::result_t res;
  slfr_pkg::result_t out_res_r;

  assign in_req.ready = !out_valid_r || out_req.ready;
  assign in_fire      = in_req.valid && in_req.ready;

  // step sequencer; state advances only on an accepted request
  slfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_fire),
    .rx_byte (in_req.rx_byte),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_req.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= res;
    end
  end

  assign out_req.valid        = out_valid_r;
  assign out_req.status       = out_res_r.status;
  assign out_req.position     = out_res_r.position;
  assign out_req.data_byte    = out_res_r.data_byte;
  assign out_req.frame_length = out_res_r.frame_length;

endmodule

`default_nettype wire

@@ sv/slfr_checker.sv @@
// Port-level checks for the frame receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module slfr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [5:0] out_position,
  input wire logic [7:0] out_data_byte,
  input wire logic [5:0] out_frame_length
);

  localparam logic [5:0] LEN_SAT = 6'(slfr_pkg::FRAME_LEN_SAT);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_position) && $stable(out_data_byte) && $stable(out_frame_length))
    else $error("stalled result changed");

  // nothing is taken while a result waits unaccepted
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted over a stalled result");

  // completion carries the frame length, other results carry zero
  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == slfr_pkg::ST_DONE) ? (out_frame_length == LEN_SAT)
                                                     : (out_frame_length == 6'd0)))
    else $error("frame length mismatch");

  // ignored and aborted bytes report no position or data
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == slfr_pkg::ST_IGNORED || out_status == slfr_pkg::ST_ABORT)
      |-> out_position == 6'd0 && out_data_byte == 8'd0)
    else $error("dropped byte carries payload");

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind sync_length_frame_receiver slfr_checker u_slfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_req.ready),
  .out_valid        (out_req.valid),
  .out_ready        (out_req.ready),
  .out_status       (out_req.status),
  .out_position     (out_req.position),
  .out_data_byte    (out_req.data_byte),
  .out_frame_length (out_req.frame_length)
);

`default_nettype wire
